[rtl/triangle_barycentric_scan_fill_assert.svh]
// Assertion macros shared by the scan fill RTL.
// Each macro expects clk and rst_n to be in scope.
`ifndef TRIANGLE_BARYCENTRIC_SCAN_FILL_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_SCAN_FILL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TBSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbsf assertion failed");
// Next-cycle implication
`define TBSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbsf assertion failed");
`else
`define TBSF_ASSERT_NOW(lbl, ante, cons)
`define TBSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/tbsf_pkg.sv]
`timescale 1ns / 1ps
package tbsf_pkg;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } reg_idx_t;

  localparam int RST_AX = 400;
  localparam int RST_AY = 200;
  localparam int RST_BX = 200;
  localparam int RST_BY = 400;
  localparam int RST_CX = 600;
  localparam int RST_CY = 400;

  // Depth of the pixel queue between scanner and coverage pipeline
  localparam int Q_DEPTH = 4;

  // Scanner sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DET  = 3'b100
  } front_state_t;

endpackage

[rtl/tbsf_front.sv]
`timescale 1ns / 1ps
`include "triangle_barycentric_scan_fill_assert.svh"
module tbsf_front #(
  parameter int CB = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Latched vertex registers
  input  logic [CB-1:0]         ax,
  input  logic [CB-1:0]         ay,
  input  logic [CB-1:0]         bx,
  input  logic [CB-1:0]         by,
  input  logic [CB-1:0]         cx,
  input  logic [CB-1:0]         cy,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  // Pixel queue write side
  output logic                  tok_push,
  output logic [2*CB:0]         tok_data,
  input  logic                  q_full,
  // No pixel left in the queue or in the stages that read the setup
  input  logic                  back_idle,
  // Triangle setup for the coverage pipeline
  output logic [CB-1:0]         org_x,
  output logic [CB-1:0]         org_y,
  output logic signed [CB:0]    edge_ux,
  output logic signed [CB:0]    edge_uy,
  output logic signed [CB:0]    edge_vx,
  output logic signed [CB:0]    edge_vy,
  output logic signed [2*CB+2:0] det
);
  import tbsf_pkg::*;

  localparam int EW = CB + 1;
  localparam int PW = 2 * EW;
  localparam int DW = PW + 1;

  front_state_t            state_r, state_nxt;
  logic                    active_r, active_nxt;
  logic [CB-1:0]           sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CB-1:0]           bx0_r, bx1_r, by0_r, by1_r;
  logic [CB-1:0]           ox_r, oy_r;
  logic signed [EW-1:0]    ux_r, uy_r, vx_r, vy_r;
  logic signed [PW-1:0]    pd0_r, pd1_r;
  logic signed [DW-1:0]    det_r;
  logic [CB-1:0]           min_x, max_x, min_y, max_y;
  logic                    accept, do_setup, tok_last;

  assign accept   = in_valid && in_ready;
  assign do_setup = accept && (in_restart || !active_r);
  // Hold a setup until older pixels no longer need the current triangle
  assign in_ready = (state_r == ST_IDLE) && !q_full &&
                    (back_idle || !(in_restart || !active_r));

  // Bounding box of the current vertices
  always_comb begin
    min_x = (ax < bx) ? ax : bx;
    min_x = (cx < min_x) ? cx : min_x;
    max_x = (ax > bx) ? ax : bx;
    max_x = (cx > max_x) ? cx : max_x;
    min_y = (ay < by) ? ay : by;
    min_y = (cy < min_y) ? cy : min_y;
    max_y = (ay > by) ? ay : by;
    max_y = (cy > max_y) ? cy : max_y;
  end

  // Sequencer and scan counters
  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    tok_push   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (do_setup) begin
          state_nxt = ST_MUL;
          sx_nxt    = min_x;
          sy_nxt    = min_y;
        end else if (accept) begin
          tok_push = 1'b1;
          if (sy_r < by1_r) begin
            sy_nxt = sy_r + 1'b1;
          end else begin
            sy_nxt = by0_r;
            sx_nxt = (sx_r < bx1_r) ? sx_r + 1'b1 : bx0_r;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DET;
      end
      ST_DET: begin
        // Emit the box corner once the queue has room
        if (!q_full) begin
          tok_push   = 1'b1;
          active_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign tok_last = (sx_nxt == bx1_r) && (sy_nxt == by1_r);
  assign tok_data = {sx_nxt, sy_nxt, tok_last};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
  end

  // Scan position and triangle setup
  always_ff @(posedge clk) begin
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
    if (do_setup) begin
      bx0_r <= min_x;
      bx1_r <= max_x;
      by0_r <= min_y;
      by1_r <= max_y;
      ox_r  <= ax;
      oy_r  <= ay;
      ux_r  <= {1'b0, bx} - {1'b0, ax};
      uy_r  <= {1'b0, by} - {1'b0, ay};
      vx_r  <= {1'b0, cx} - {1'b0, ax};
      vy_r  <= {1'b0, cy} - {1'b0, ay};
    end
    if (state_r == ST_MUL) begin
      pd0_r <= ux_r * vy_r;
      pd1_r <= uy_r * vx_r;
    end
    if (state_r == ST_DET) begin
      det_r <= {pd0_r[PW-1], pd0_r} - {pd1_r[PW-1], pd1_r};
    end
  end

  assign org_x   = ox_r;
  assign org_y   = oy_r;
  assign edge_ux = ux_r;
  assign edge_uy = uy_r;
  assign edge_vx = vx_r;
  assign edge_vy = vy_r;
  assign det     = det_r;

  `TBSF_ASSERT_NEXT(a_setup_starts_mul, do_setup, state_r == ST_MUL)
  `TBSF_ASSERT_NOW(a_push_has_room, tok_push, !q_full)
  `TBSF_ASSERT_NOW(a_scan_in_box, active_r && state_r == ST_IDLE,
                   sx_r >= bx0_r && sx_r <= bx1_r && sy_r >= by0_r && sy_r <= by1_r)

endmodule

[rtl/tbsf_fifo.sv]
`timescale 1ns / 1ps
`include "triangle_barycentric_scan_fill_assert.svh"
module tbsf_fifo #(
  parameter int W     = 23,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  output logic         rvalid,
  input  logic         pop,
  output logic [W-1:0] rdata
);
  import tbsf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full   = (count_r == CW'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem[rd_ptr_r];
  assign do_pop = pop && rvalid;

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `TBSF_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `TBSF_ASSERT_NEXT(a_count_up, push && !do_pop, count_r == $past(count_r) + 1'b1)
  `TBSF_ASSERT_NEXT(a_count_down, do_pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

[rtl/tbsf_back.sv]
`timescale 1ns / 1ps
module tbsf_back #(
  parameter int CB = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Pixel queue read side
  input  logic                   tok_valid,
  input  logic [2*CB:0]          tok_data,
  output logic                   tok_pop,
  // A pixel still depends on the triangle setup
  output logic                   pipe_busy,
  // Triangle setup
  input  logic [CB-1:0]          org_x,
  input  logic [CB-1:0]          org_y,
  input  logic signed [CB:0]     edge_ux,
  input  logic signed [CB:0]     edge_uy,
  input  logic signed [CB:0]     edge_vx,
  input  logic signed [CB:0]     edge_vy,
  input  logic signed [2*CB+2:0] det,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CB-1:0]          out_pixel_x,
  output logic [CB-1:0]          out_pixel_y,
  output logic                   out_covered,
  output logic                   out_last
);
  import tbsf_pkg::*;

  localparam int EW = CB + 1;
  localparam int PW = 2 * EW;
  localparam int DW = PW + 1;

  logic                 adv;
  logic                 v1_r, v2_r, v3_r, vo_r;
  logic [CB-1:0]        x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, xo_r, yo_r;
  logic                 l1_r, l2_r, l3_r, lo_r, co_r;
  logic signed [EW-1:0] wx1_r, wy1_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [DW-1:0] s_r, t_r;
  logic signed [DW:0]   st_sum, det_x;
  logic                 covered_nxt;

  // Whole pipeline moves when the output slot is free or being taken
  assign adv       = !vo_r || out_ready;
  assign tok_pop   = adv;
  assign pipe_busy = v1_r || v2_r || v3_r;

  // Coverage test; sign of det picks the orientation
  always_comb begin
    st_sum = {s_r[DW-1], s_r} + {t_r[DW-1], t_r};
    det_x  = {det[DW-1], det};
    if (det == '0) begin
      covered_nxt = 1'b0;
    end else if (!det[DW-1]) begin
      covered_nxt = !s_r[DW-1] && !t_r[DW-1] && (st_sum <= det_x);
    end else begin
      covered_nxt = (s_r[DW-1] || s_r == '0) && (t_r[DW-1] || t_r == '0) &&
                    (st_sum >= det_x);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= tok_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  // Offsets, products, numerators, flag
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= tok_data[2*CB:CB+1];
      y1_r  <= tok_data[CB:1];
      l1_r  <= tok_data[0];
      wx1_r <= {1'b0, tok_data[2*CB:CB+1]} - {1'b0, org_x};
      wy1_r <= {1'b0, tok_data[CB:1]} - {1'b0, org_y};

      x2_r <= x1_r;
      y2_r <= y1_r;
      l2_r <= l1_r;
      pa_r <= wx1_r * edge_vy;
      pb_r <= wy1_r * edge_vx;
      pc_r <= edge_ux * wy1_r;
      pd_r <= edge_uy * wx1_r;

      x3_r <= x2_r;
      y3_r <= y2_r;
      l3_r <= l2_r;
      s_r  <= {pa_r[PW-1], pa_r} - {pb_r[PW-1], pb_r};
      t_r  <= {pc_r[PW-1], pc_r} - {pd_r[PW-1], pd_r};

      xo_r <= x3_r;
      yo_r <= y3_r;
      lo_r <= l3_r;
      co_r <= covered_nxt;
    end
  end

  assign out_valid   = vo_r;
  assign out_pixel_x = xo_r;
  assign out_pixel_y = yo_r;
  assign out_covered = co_r;
  assign out_last    = lo_r;

endmodule

[rtl/triangle_barycentric_scan_fill.sv]
`timescale 1ns / 1ps
// Barycentric triangle scan fill.
// Six vertex registers (A, B, C as x/y pairs) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle (not enforced). Each input transfer yields exactly one output pixel:
// x is the outer scan loop, y the inner, over the triangle's bounding box.
// A transfer with in_restart high, or the first one after reset, latches the
// vertices and restarts at the box corner; any other transfer steps by one.
// out_covered flags pixels inside or on the triangle (exact integer test);
// out_last marks the final box pixel, after which the scan wraps.
// Throughput: one pixel per cycle for stepping transfers; a restart holds
// in_ready low while the setup sequencer forms det; restarts are only taken
// once older pixels have left the queue and reached the output stage of the
// coverage pipeline, since those pixels still use the old triangle.
// Each pixel is written to the pixel queue, after ST_MUL and ST_DET for a
// restart, then passes through the 4-stage coverage pipeline to out_valid.
// Reset clears the scan (no triangle set up) and reloads the default
// vertices. When a pixel waits with out_ready low, the coverage pipeline
// holds, the queue fills, and in_ready then drops until room frees up.
module triangle_barycentric_scan_fill #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_covered,
  output logic                  out_last
);
  import tbsf_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int TW = 2 * CB + 1;
  localparam int DW = 2 * (CB + 1) + 1;

  logic [CB-1:0]        ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic                 tok_push, q_full, q_valid, q_pop;
  logic                 pipe_busy, back_idle;
  logic [TW-1:0]        tok_wdata, tok_rdata;
  logic [CB-1:0]        org_x, org_y;
  logic signed [CB:0]   edge_ux, edge_uy, edge_vx, edge_vy;
  logic signed [DW-1:0] det;

  // Vertex registers; out-of-range indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= CB'(RST_AX);
      ay_r <= CB'(RST_AY);
      bx_r <= CB'(RST_BX);
      by_r <= CB'(RST_BY);
      cx_r <= CB'(RST_CX);
      cy_r <= CB'(RST_CY);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AX:  ax_r <= cfg_wdata;
        REG_AY:  ay_r <= cfg_wdata;
        REG_BX:  bx_r <= cfg_wdata;
        REG_BY:  by_r <= cfg_wdata;
        REG_CX:  cx_r <= cfg_wdata;
        REG_CY:  cy_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Nothing in flight still reads the triangle setup
  assign back_idle = !q_valid && !pipe_busy;

  tbsf_front #(.CB(CB)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ax         (ax_r),
    .ay         (ay_r),
    .bx         (bx_r),
    .by         (by_r),
    .cx         (cx_r),
    .cy         (cy_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .tok_push   (tok_push),
    .tok_data   (tok_wdata),
    .q_full     (q_full),
    .back_idle  (back_idle),
    .org_x      (org_x),
    .org_y      (org_y),
    .edge_ux    (edge_ux),
    .edge_uy    (edge_uy),
    .edge_vx    (edge_vx),
    .edge_vy    (edge_vy),
    .det        (det)
  );

  tbsf_fifo #(.W(TW), .DEPTH(Q_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (tok_push),
    .wdata  (tok_wdata),
    .full   (q_full),
    .rvalid (q_valid),
    .pop    (q_pop),
    .rdata  (tok_rdata)
  );

  tbsf_back #(.CB(CB)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (q_valid),
    .tok_data    (tok_rdata),
    .tok_pop     (q_pop),
    .pipe_busy   (pipe_busy),
    .org_x       (org_x),
    .org_y       (org_y),
    .edge_ux     (edge_ux),
    .edge_uy     (edge_uy),
    .edge_vx     (edge_vx),
    .edge_vy     (edge_vy),
    .det         (det),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_covered (out_covered),
    .out_last    (out_last)
  );

endmodule
